/* rtl/case_insensitive_find_replace_unit_macros.svh */
// ----------------------------------------------------------------------------
// Case-insensitive find/replace unit: assertion macros
// Concurrent assertion shorthands clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_FIND_REPLACE_UNIT_MACROS_SVH
`define CASE_INSENSITIVE_FIND_REPLACE_UNIT_MACROS_SVH

// same-cycle implication
`define CIFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CIFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cifr_pkg.sv */
// ----------------------------------------------------------------------------
// Case-insensitive find/replace package
// Transaction payload types, register indexes, fixed sizes and a case-fold function.
// ----------------------------------------------------------------------------
`default_nettype none

package cifr_pkg;

   localparam int BYTE_W     = 8;
   localparam int PAT_W      = 64;
   localparam int LEN_W      = 4;
   localparam int CAP_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int RES_DEPTH  = 8;
   localparam int RES_CNT_W  = 4;
   localparam int REPL_MAX   = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIND_LENGTH     = 3'd0,
      CSR_FIND_PATTERN    = 3'd1,
      CSR_REPLACE_LENGTH  = 3'd2,
      CSR_REPLACE_PATTERN = 3'd3,
      CSR_OUT_CAPACITY    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              out_last;
      logic              truncated;
   } rsp_payload_type;

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/case_insensitive_find_replace_unit.sv */
// ----------------------------------------------------------------------------
// Case-insensitive find/replace unit
// Streams text bytes through a pattern window and emits the rewritten text.
//
//   channel | direction | payload          | accepted when
//   req     | in        | in_byte, in_last | req_valid & req_ready
//   rsp     | out       | out_byte, flags  | rsp_valid & rsp_ready
//   csr     | in        | index, wdata     | csr_valid & csr_ready
//
// One input transaction per cycle is taken while each yields at most one result and rsp_ready is high.
// A transaction yields 0 to 8 results, loaded at once into an 8-entry result
// shift buffer and drained one per cycle while rsp_ready is high; the buffer drain sets the rate.
// Input is taken when the buffer is empty or its final entry leaves.
// Synchronous reset clears stream state and buffer count and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "case_insensitive_find_replace_unit_macros.svh"

module case_insensitive_find_replace_unit #(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire cifr_pkg::req_payload_type             req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output cifr_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cifr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [cifr_pkg::PAT_W-1:0]            csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);

   logic [cifr_pkg::LEN_W-1:0]  find_len_ff;
   logic [cifr_pkg::PAT_W-1:0]  find_pat_ff;
   logic [cifr_pkg::LEN_W-1:0]  repl_len_ff;
   logic [cifr_pkg::PAT_W-1:0]  repl_pat_ff;
   logic [cifr_pkg::CAP_W-1:0]  out_cap_ff;

   logic [cifr_pkg::BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [cifr_pkg::BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [CNT_W-1:0]            win_count_ff, win_count_in;
   logic [cifr_pkg::CAP_W-1:0]  emitted_ff, emitted_in;
   logic                        stopped_ff, stopped_in;
   logic                        dropped_ff, dropped_in;

   logic [cifr_pkg::BYTE_W-1:0]    res_bytes_ff [cifr_pkg::RES_DEPTH];
   logic [cifr_pkg::BYTE_W-1:0]    res_bytes_in [cifr_pkg::RES_DEPTH];
   logic [cifr_pkg::RES_CNT_W-1:0] res_count_ff, res_count_in;
   logic                           res_last_ff, res_last_in;
   logic                           res_trunc_ff, res_trunc_in;
   logic                           res_bare_ff, res_bare_in;

   logic [cifr_pkg::BYTE_W-1:0] wn [cifr_pkg::RES_DEPTH];
   logic [MAX_PATTERN-1:0]      eq;
   logic [CNT_W-1:0]            flen;
   logic [CNT_W-1:0]            cnt_ins;
   logic                        do_insert, full, match;
   logic                        accept, pop;
   logic [cifr_pkg::LEN_W-1:0]  rlen;
   logic [cifr_pkg::CAP_W:0]    e_p1, e_prl;
   logic [cifr_pkg::CAP_W-1:0]  space;
   logic                        lit_ok, rep_ok;
   logic [cifr_pkg::RES_CNT_W-1:0] room, lit_want, lit_n, n_data;
   logic                        sel_rep, stop_set, drop_lit, shift;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (res_count_ff == '0) ||
                      ((res_count_ff == cifr_pkg::RES_CNT_W'(1)) && rsp_ready);

   always_comb begin
      if (find_len_ff == '0) begin
         flen = CNT_W'(1);
      end else if (find_len_ff > cifr_pkg::LEN_W'(MAX_PATTERN)) begin
         flen = CNT_W'(MAX_PATTERN);
      end else begin
         flen = CNT_W'(find_len_ff);
      end
      rlen = (repl_len_ff > cifr_pkg::LEN_W'(cifr_pkg::REPL_MAX)) ?
             cifr_pkg::LEN_W'(cifr_pkg::REPL_MAX) : repl_len_ff;
   end

   assign do_insert = !stopped_ff && (win_count_ff < flen);
   assign cnt_ins   = win_count_ff + CNT_W'(do_insert);
   assign full      = do_insert && (cnt_ins == flen);

   for (genvar g = 0; g < cifr_pkg::RES_DEPTH; g++) begin : g_wn
      if (g < MAX_PATTERN) begin : g_live
         assign wn[g] = (do_insert && (win_count_ff == CNT_W'(g))) ?
                        req_payload.in_byte : win_ff[g];
         assign eq[g] = (cifr_pkg::fold(wn[g]) == cifr_pkg::fold(find_pat_ff[8*g +: 8])) ||
                        (CNT_W'(g) >= flen);
      end else begin : g_pad
         assign wn[g] = '0;
      end
   end

   assign match = full && (&eq);

   always_comb begin
      e_p1   = {1'b0, emitted_ff} + (cifr_pkg::CAP_W+1)'(1);
      e_prl  = {1'b0, emitted_ff} + (cifr_pkg::CAP_W+1)'(rlen);
      lit_ok = e_p1 < {1'b0, out_cap_ff};
      rep_ok = e_prl < {1'b0, out_cap_ff};
      space  = out_cap_ff - emitted_ff - cifr_pkg::CAP_W'(1);
      if (!lit_ok) begin
         room = '0;
      end else if (space >= cifr_pkg::CAP_W'(cifr_pkg::RES_DEPTH)) begin
         room = cifr_pkg::RES_CNT_W'(cifr_pkg::RES_DEPTH);
      end else begin
         room = space[cifr_pkg::RES_CNT_W-1:0];
      end
   end

   always_comb begin
      sel_rep      = 1'b0;
      stop_set     = 1'b0;
      shift        = 1'b0;
      lit_want     = '0;
      win_count_in = cnt_ins;
      if (match) begin
         win_count_in = '0;
         if (rep_ok) begin
            sel_rep = 1'b1;
         end else begin
            stop_set = 1'b1;
         end
      end else if (full) begin
         shift        = 1'b1;
         win_count_in = flen - CNT_W'(1);
         lit_want     = req_payload.in_last ? cifr_pkg::RES_CNT_W'(flen) :
                                              cifr_pkg::RES_CNT_W'(1);
      end else if (req_payload.in_last && !stopped_ff) begin
         lit_want = cifr_pkg::RES_CNT_W'(cnt_ins);
      end
      lit_n      = (lit_want < room) ? lit_want : room;
      drop_lit   = lit_want > room;
      n_data     = sel_rep ? cifr_pkg::RES_CNT_W'(rlen) : lit_n;
      emitted_in = emitted_ff + cifr_pkg::CAP_W'(n_data);
      stopped_in = stopped_ff | stop_set;
      dropped_in = dropped_ff | stop_set | drop_lit;
   end

   always_comb begin
      for (int k = 0; k < MAX_PATTERN - 1; k++) begin
         win_in[k] = shift ? wn[k+1] : wn[k];
      end
      win_in[MAX_PATTERN-1] = wn[MAX_PATTERN-1];
   end

   always_comb begin
      for (int k = 0; k < cifr_pkg::RES_DEPTH; k++) begin
         res_bytes_in[k] = sel_rep ? repl_pat_ff[8*k +: 8] : wn[k];
      end
      res_last_in  = req_payload.in_last;
      res_bare_in  = req_payload.in_last && (n_data == '0);
      res_count_in = res_bare_in ? cifr_pkg::RES_CNT_W'(1) : n_data;
      res_trunc_in = res_bare_in ? dropped_in : dropped_ff;
   end

   assign rsp_valid              = res_count_ff != '0;
   assign rsp_payload.out_byte   = res_bare_ff ? '0 : res_bytes_ff[0];
   assign rsp_payload.byte_valid = !res_bare_ff;
   assign rsp_payload.out_last   = res_last_ff && (res_count_ff == cifr_pkg::RES_CNT_W'(1));
   assign rsp_payload.truncated  = res_trunc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_count_ff <= '0;
      end else if (accept) begin
         res_count_ff <= res_count_in;
      end else if (pop) begin
         res_count_ff <= res_count_ff - cifr_pkg::RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_bytes_ff <= res_bytes_in;
         res_last_ff  <= res_last_in;
         res_trunc_ff <= res_trunc_in;
         res_bare_ff  <= res_bare_in;
      end else if (pop) begin
         for (int k = 0; k < cifr_pkg::RES_DEPTH - 1; k++) begin
            res_bytes_ff[k] <= res_bytes_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_count_ff <= '0;
         emitted_ff   <= '0;
         stopped_ff   <= 1'b0;
         dropped_ff   <= 1'b0;
      end else begin
         if (accept) begin
            if (req_payload.in_last) begin
               win_count_ff <= '0;
               emitted_ff   <= '0;
               stopped_ff   <= 1'b0;
               dropped_ff   <= 1'b0;
            end else begin
               win_count_ff <= win_count_in;
               emitted_ff   <= emitted_in;
               stopped_ff   <= stopped_in;
               dropped_ff   <= dropped_in;
            end
         end
         if (csr_valid && (csr_index == cifr_pkg::CSR_FIND_LENGTH)) begin
            win_count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_len_ff <= cifr_pkg::LEN_W'(1);
         find_pat_ff <= '0;
         repl_len_ff <= '0;
         repl_pat_ff <= '0;
         out_cap_ff  <= cifr_pkg::CAP_W'(1024);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cifr_pkg::CSR_FIND_LENGTH: begin
               find_len_ff <= csr_wdata[cifr_pkg::LEN_W-1:0];
            end
            cifr_pkg::CSR_FIND_PATTERN: begin
               find_pat_ff <= csr_wdata;
            end
            cifr_pkg::CSR_REPLACE_LENGTH: begin
               repl_len_ff <= csr_wdata[cifr_pkg::LEN_W-1:0];
            end
            cifr_pkg::CSR_REPLACE_PATTERN: begin
               repl_pat_ff <= csr_wdata;
            end
            cifr_pkg::CSR_OUT_CAPACITY: begin
               out_cap_ff <= csr_wdata[cifr_pkg::CAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   `CIFR_ASSERT_SAME(a_stop_implies_drop, stopped_ff, dropped_ff, "stopped without drop flag")
   `CIFR_ASSERT_SAME(a_window_below_len, 1'b1, win_count_ff < flen, "window count reached pattern length")
   `CIFR_ASSERT_NEXT(a_last_restarts, accept && req_payload.in_last, (win_count_ff == '0) && (emitted_ff == '0) && !stopped_ff && !dropped_ff, "stream state not restarted after final byte")

endmodule

`default_nettype wire
